FILE: hw/rtl/nvmfr_pkg.sv
`timescale 1ns / 1ps

package nvmfr_pkg;

   localparam int ADDR_W = 15;
   localparam int WORD_W = 14;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 3;
   localparam int STAT_W = 2;

   localparam int FLASH_WORDS_DEF = 1024;
   localparam int ROW_WORDS_DEF   = 32;

   localparam logic [WORD_W-1:0] WORD_ERASED = 14'h3FFF;
   localparam logic [BYTE_W-1:0] UNLOCK_KEY1 = 8'h55;
   localparam logic [BYTE_W-1:0] UNLOCK_KEY2 = 8'hAA;

   localparam logic MODE_WRITE = 1'b1;

   // control register bit positions
   localparam int CTL_READ   = 0;
   localparam int CTL_START  = 1;
   localparam int CTL_ENABLE = 2;
   localparam int CTL_ERROR  = 3;
   localparam int CTL_ERASE  = 4;
   localparam int CTL_LATCH  = 5;
   localparam int CTL_CONFIG = 6;

   typedef enum logic [IDX_W-1:0] {
      REG_ADDR_LO = 3'd0,
      REG_ADDR_HI = 3'd1,
      REG_DATA_LO = 3'd2,
      REG_DATA_HI = 3'd3,
      REG_CTRL    = 3'd4,
      REG_UNLOCK  = 3'd5
   } reg_idx_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 2'd0,
      ST_LOCKED      = 2'd1,
      ST_NOT_ENABLED = 2'd2,
      ST_RANGE       = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      UL_LOCKED = 2'd0,
      UL_HALF   = 2'd1,
      UL_OPEN   = 2'd2
   } unlock_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_ERASE = 2'd1,
      OP_LATCH = 2'd2,
      OP_PROG  = 2'd3
   } op_type;

   typedef struct packed {
      logic accept;
      logic init_step;
      logic read_ld;
      logic latch_wr;
      logic erase_step;
      logic prog_step;
      logic lat_clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic   init_last;
      logic   erase_last;
      logic   prog_last;
      logic   dec_read;
      op_type dec_op;
      op_type op_q;
   } sts_type;

endpackage

FILE: hw/rtl/nvmfr_ctrl.sv
`timescale 1ns / 1ps

module nvmfr_ctrl import nvmfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_LATCH = 7'b0001000,
      S_ERASE = 7'b0010000,
      S_PROG  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   function automatic state_type op_state(input op_type op);
      state_type s;
      case (op)
         OP_ERASE: s = S_ERASE;
         OP_LATCH: s = S_LATCH;
         OP_PROG:  s = S_PROG;
         default:  s = S_DONE;
      endcase
      return s;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.dec_read ? S_READ : op_state(sts.dec_op);
            end
         end
         S_READ: begin
            cmd.read_ld = 1'b1;
            state_in    = op_state(sts.op_q);
         end
         S_LATCH: begin
            cmd.latch_wr = 1'b1;
            state_in     = S_DONE;
         end
         S_ERASE: begin
            cmd.erase_step = 1'b1;
            if (sts.erase_last) state_in = S_DONE;
         end
         S_PROG: begin
            cmd.prog_step = 1'b1;
            if (sts.prog_last) begin
               cmd.lat_clear = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff != S_IDLE))
      else $error("item accepted but controller stayed idle");

   a_prog_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROG && sts.prog_last) |=> (state_ff == S_DONE))
      else $error("program sweep did not complete");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule

FILE: hw/rtl/nvmfr_datapath.sv
`timescale 1ns / 1ps

module nvmfr_datapath import nvmfr_pkg::*; #(
   parameter int FLASH_WORDS = FLASH_WORDS_DEF,
   parameter int ROW_WORDS   = ROW_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_mode,
   input  logic [IDX_W-1:0]  req_reg_index,
   input  logic [BYTE_W-1:0] req_write_data,
   output logic [BYTE_W-1:0] rsp_read_data,
   output logic [STAT_W-1:0] rsp_status,
   input  cmd_type           cmd,
   output sts_type           sts
);

   localparam int FA_W = $clog2(FLASH_WORDS);
   localparam int RI_W = $clog2(ROW_WORDS);
   localparam int RC_W = $clog2(ROW_WORDS + 1);
   localparam int RS   = ADDR_W + RI_W;
   localparam longint RECIP = ((longint'(1) << RS) + ROW_WORDS - 1) / ROW_WORDS;
   localparam logic [ADDR_W:0]   RECIP_V = (ADDR_W+1)'(RECIP);
   localparam logic [ADDR_W:0]   FW_LIM  = (ADDR_W+1)'(FLASH_WORDS);
   localparam logic [ADDR_W-1:0] RW_V    = ADDR_W'(ROW_WORDS);

   logic [WORD_W-1:0] flash_mem [FLASH_WORDS];
   logic [WORD_W-1:0] lat_mem   [ROW_WORDS];

   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [WORD_W-1:0]    data_ff, data_in;
   logic                 en_ff, en_in, erase_ff, erase_in, latch_ff, latch_in;
   logic                 cfg_ff, cfg_in, err_ff, err_in;
   unlock_type           phase_ff, phase_in;
   op_type               op_ff, op_in;
   logic [BYTE_W-1:0]    res_rd_ff, res_rd_in, rsp_rd_ff, rsp_rd_in;
   stat_type             res_st_ff, res_st_in, rsp_st_ff, rsp_st_in;
   logic [FA_W-1:0]      init_cnt_ff, init_cnt_in;
   logic [RC_W-1:0]      row_cnt_ff, row_cnt_in;
   logic [ROW_WORDS-1:0] lat_vld_ff, lat_vld_in;
   logic [ADDR_W-1:0]    q_ff, base_ff;
   logic [WORD_W-1:0]    flash_q_ff, lat_q_ff;
   logic                 p_act_ff, p_act_in, p_slot_ff, p_vld_ff;
   logic [FA_W-1:0]      p_addr_ff;

   logic [2*ADDR_W:0]    prod;
   logic [RI_W-1:0]      slot, row_idx;
   logic [ADDR_W:0]      row_addr;
   logic                 row_ok, prog_rd;
   logic                 wr, addr_ok, ctl_wr, rd_cmd, st_cmd;
   logic                 start_fail, start_go, dec_read;
   reg_idx_type          idx;
   logic [BYTE_W-1:0]    b, rd_val, ctl_byte;
   stat_type             start_st, read_st, item_st;
   op_type               dec_op;
   unlock_type           phase_nx;
   logic                 fl_ren, fl_we;
   logic [FA_W-1:0]      fl_raddr, fl_waddr;
   logic [WORD_W-1:0]    fl_wdata, p_lat;

   // row base by reciprocal multiply, two registered stages
   assign prod    = (2*ADDR_W+1)'(addr_ff) * (2*ADDR_W+1)'(RECIP_V);
   assign slot    = RI_W'(addr_ff - base_ff);
   assign row_idx = row_cnt_ff[RI_W-1:0];
   assign row_addr = {1'b0, base_ff} + (ADDR_W+1)'(row_cnt_ff);
   assign row_ok  = row_addr < FW_LIM;
   assign prog_rd = cmd.prog_step && (row_cnt_ff < RC_W'(ROW_WORDS));

   assign wr      = (req_mode == MODE_WRITE);
   assign idx     = reg_idx_type'(req_reg_index);
   assign b       = req_write_data;
   assign addr_ok = {1'b0, addr_ff} < FW_LIM;
   assign ctl_wr  = wr && (idx == REG_CTRL);
   assign rd_cmd  = ctl_wr && b[CTL_READ];
   assign st_cmd  = ctl_wr && b[CTL_START];
   assign dec_read   = rd_cmd && !b[CTL_CONFIG] && addr_ok;
   assign start_fail = st_cmd && ((phase_ff != UL_OPEN) || !b[CTL_ENABLE]);
   assign start_go   = st_cmd && (phase_ff == UL_OPEN) && b[CTL_ENABLE]
                       && !b[CTL_CONFIG] && addr_ok;

   always_comb begin
      if (phase_ff != UL_OPEN)   start_st = ST_LOCKED;
      else if (!b[CTL_ENABLE])   start_st = ST_NOT_ENABLED;
      else if (b[CTL_CONFIG])    start_st = ST_OK;
      else if (!addr_ok)         start_st = ST_RANGE;
      else                       start_st = ST_OK;
      read_st = (rd_cmd && !b[CTL_CONFIG] && !addr_ok) ? ST_RANGE : ST_OK;
      item_st = (st_cmd && start_st != ST_OK) ? start_st : read_st;

      if (!start_go)          dec_op = OP_NONE;
      else if (b[CTL_ERASE])  dec_op = OP_ERASE;
      else if (b[CTL_LATCH])  dec_op = OP_LATCH;
      else                    dec_op = OP_PROG;

      if (wr && idx == REG_UNLOCK && b == UNLOCK_KEY1)
         phase_nx = UL_HALF;
      else if (wr && idx == REG_UNLOCK && b == UNLOCK_KEY2 && phase_ff == UL_HALF)
         phase_nx = UL_OPEN;
      else
         phase_nx = UL_LOCKED;

      ctl_byte             = '0;
      ctl_byte[CTL_ENABLE] = en_ff;
      ctl_byte[CTL_ERROR]  = err_ff;
      ctl_byte[CTL_ERASE]  = erase_ff;
      ctl_byte[CTL_LATCH]  = latch_ff;
      ctl_byte[CTL_CONFIG] = cfg_ff;

      rd_val = '0;
      if (!wr) begin
         case (idx)
            REG_ADDR_LO: rd_val = addr_ff[7:0];
            REG_ADDR_HI: rd_val = BYTE_W'(addr_ff[ADDR_W-1:8]);
            REG_DATA_LO: rd_val = data_ff[7:0];
            REG_DATA_HI: rd_val = BYTE_W'(data_ff[WORD_W-1:8]);
            REG_CTRL:    rd_val = ctl_byte;
            default:     rd_val = '0;
         endcase
      end
   end

   always_comb begin
      addr_in     = addr_ff;
      data_in     = data_ff;
      en_in       = en_ff;
      erase_in    = erase_ff;
      latch_in    = latch_ff;
      cfg_in      = cfg_ff;
      err_in      = err_ff;
      phase_in    = phase_ff;
      op_in       = op_ff;
      res_rd_in   = res_rd_ff;
      res_st_in   = res_st_ff;
      rsp_rd_in   = rsp_rd_ff;
      rsp_st_in   = rsp_st_ff;
      lat_vld_in  = lat_vld_ff;
      init_cnt_in = cmd.init_step ? init_cnt_ff + 1'b1 : init_cnt_ff;
      row_cnt_in  = (cmd.erase_step || cmd.prog_step) ? row_cnt_ff + 1'b1 : '0;
      p_act_in    = prog_rd && row_ok;

      if (cmd.accept) begin
         res_rd_in = rd_val;
         res_st_in = item_st;
         op_in     = dec_op;
         phase_in  = phase_nx;
         if (wr) begin
            case (idx)
               REG_ADDR_LO: addr_in[7:0]          = b;
               REG_ADDR_HI: addr_in[ADDR_W-1:8]   = b[ADDR_W-9:0];
               REG_DATA_LO: data_in[7:0]          = b;
               REG_DATA_HI: data_in[WORD_W-1:8]   = b[WORD_W-9:0];
               REG_CTRL: begin
                  en_in    = b[CTL_ENABLE];
                  erase_in = b[CTL_ERASE];
                  latch_in = b[CTL_LATCH];
                  cfg_in   = b[CTL_CONFIG];
                  err_in   = b[CTL_ERROR] || start_fail;
                  if (rd_cmd && !dec_read) data_in = '0;
               end
               default: ;
            endcase
         end
      end
      if (cmd.read_ld) data_in = flash_q_ff;
      if (cmd.latch_wr) lat_vld_in[slot] = 1'b1;
      if (cmd.lat_clear) lat_vld_in = '0;
      if (cmd.finish) begin
         rsp_rd_in = res_rd_ff;
         rsp_st_in = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         data_ff     <= '0;
         en_ff       <= 1'b0;
         erase_ff    <= 1'b0;
         latch_ff    <= 1'b0;
         cfg_ff      <= 1'b0;
         err_ff      <= 1'b0;
         phase_ff    <= UL_LOCKED;
         op_ff       <= OP_NONE;
         init_cnt_ff <= '0;
         row_cnt_ff  <= '0;
         lat_vld_ff  <= '0;
         p_act_ff    <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         data_ff     <= data_in;
         en_ff       <= en_in;
         erase_ff    <= erase_in;
         latch_ff    <= latch_in;
         cfg_ff      <= cfg_in;
         err_ff      <= err_in;
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         init_cnt_ff <= init_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         lat_vld_ff  <= lat_vld_in;
         p_act_ff    <= p_act_in;
      end
   end

   always_ff @(posedge clock) begin
      res_rd_ff <= res_rd_in;
      res_st_ff <= res_st_in;
      rsp_rd_ff <= rsp_rd_in;
      rsp_st_ff <= rsp_st_in;
      q_ff      <= ADDR_W'(prod >> RS);
      base_ff   <= ADDR_W'(q_ff * RW_V);
      p_slot_ff <= (row_idx == slot);
      p_vld_ff  <= lat_vld_ff[row_idx];
      p_addr_ff <= row_addr[FA_W-1:0];
   end

   // flash array port selection
   assign p_lat = p_slot_ff ? data_ff : (p_vld_ff ? lat_q_ff : WORD_ERASED);

   always_comb begin
      fl_ren   = 1'b0;
      fl_raddr = addr_ff[FA_W-1:0];
      if (cmd.accept && dec_read) begin
         fl_ren = 1'b1;
      end else if (prog_rd && row_ok) begin
         fl_ren   = 1'b1;
         fl_raddr = row_addr[FA_W-1:0];
      end

      fl_we    = 1'b0;
      fl_waddr = init_cnt_ff;
      fl_wdata = WORD_ERASED;
      if (cmd.init_step) begin
         fl_we = 1'b1;
      end else if (cmd.erase_step && row_ok) begin
         fl_we    = 1'b1;
         fl_waddr = row_addr[FA_W-1:0];
      end else if (p_act_ff) begin
         fl_we    = 1'b1;
         fl_waddr = p_addr_ff;
         fl_wdata = flash_q_ff & p_lat;
      end
   end

   always_ff @(posedge clock) begin
      if (fl_we) flash_mem[fl_waddr] <= fl_wdata;
      if (fl_ren) flash_q_ff <= flash_mem[fl_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_wr) lat_mem[slot] <= data_ff;
      if (prog_rd) lat_q_ff <= lat_mem[row_idx];
   end

   assign rsp_read_data = rsp_rd_ff;
   assign rsp_status    = rsp_st_ff;

   assign sts.init_last  = (init_cnt_ff == FA_W'(FLASH_WORDS - 1));
   assign sts.erase_last = (row_cnt_ff == RC_W'(ROW_WORDS - 1));
   assign sts.prog_last  = (row_cnt_ff == RC_W'(ROW_WORDS));
   assign sts.dec_read   = dec_read;
   assign sts.dec_op     = dec_op;
   assign sts.op_q       = op_ff;

endmodule

FILE: hw/rtl/nvm_flash_row_controller.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_mode, req_reg_index, req_write_data
// rsp       out        rsp_valid, rsp_ready, rsp_read_data, rsp_status
//
// One item in flight. A register access passes from accept to a done state that
// presents the result; a read command first passes a read state for the flash
// array port, a latch load a latch state. Erase and program sweep the row, one
// flash word per cycle through the single write port, program pipelined read
// then write.
// After reset a clearing pass writes every word erased with req_ready low. A
// waiting result sits in the output register while the next item is accepted
// and worked on.

module nvm_flash_row_controller import nvmfr_pkg::*; #(
   parameter int FLASH_WORDS = FLASH_WORDS_DEF,
   parameter int ROW_WORDS   = ROW_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [IDX_W-1:0]  req_reg_index,
   input  logic [BYTE_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_read_data,
   output logic [STAT_W-1:0] rsp_status
);

   cmd_type cmd;
   sts_type sts;

   nvmfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nvmfr_datapath #(
      .FLASH_WORDS (FLASH_WORDS),
      .ROW_WORDS   (ROW_WORDS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import nvmfr_pkg::*;

   localparam int FW = FLASH_WORDS_DEF;
   localparam int RW = ROW_WORDS_DEF;
   localparam int RANDOM_ITEMS = 700;
   localparam int DIRECTED_N = 29;
   localparam int END_WAIT = 2 * RW;

   localparam logic MODE_READ = ~MODE_WRITE;
   localparam logic [IDX_W-1:0] REG_NONE_LO = 3'd6;
   localparam logic [IDX_W-1:0] REG_NONE_HI = 3'd7;

   localparam logic [BYTE_W-1:0] C_READ   = BYTE_W'(1 << CTL_READ);
   localparam logic [BYTE_W-1:0] C_START  = BYTE_W'(1 << CTL_START);
   localparam logic [BYTE_W-1:0] C_ENABLE = BYTE_W'(1 << CTL_ENABLE);
   localparam logic [BYTE_W-1:0] C_ERROR  = BYTE_W'(1 << CTL_ERROR);
   localparam logic [BYTE_W-1:0] C_ERASE  = BYTE_W'(1 << CTL_ERASE);
   localparam logic [BYTE_W-1:0] C_LATCH  = BYTE_W'(1 << CTL_LATCH);
   localparam logic [BYTE_W-1:0] C_CONFIG = BYTE_W'(1 << CTL_CONFIG);
   localparam logic [BYTE_W-1:0] C_KEEP   = C_ENABLE | C_ERROR | C_ERASE | C_LATCH | C_CONFIG;

   typedef struct packed {
      logic [BYTE_W-1:0] rd;
      stat_type          st;
   } reply_type;

   typedef struct packed {
      logic              mode;
      logic [IDX_W-1:0]  idx;
      logic [BYTE_W-1:0] wd;
      logic              typed;
      reply_type         want;
   } access_row_type;

   // typed rows carry the reply that can be read straight off the register map
   localparam access_row_type DIRECTED [DIRECTED_N] = '{
      '{MODE_READ,  REG_CTRL,    8'h00,       1'b1, '{8'h00, ST_OK}},
      '{MODE_READ,  REG_NONE_HI, 8'hFF,       1'b1, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_ADDR_LO, 8'hFF,       1'b1, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_ADDR_HI, 8'hFF,       1'b1, '{8'h00, ST_OK}},
      '{MODE_READ,  REG_ADDR_HI, 8'h00,       1'b1, '{8'h7F, ST_OK}},
      '{MODE_WRITE, REG_CTRL,    C_READ,      1'b1, '{8'h00, ST_RANGE}},
      '{MODE_WRITE, REG_CTRL,    C_START | C_ENABLE, 1'b1, '{8'h00, ST_LOCKED}},
      '{MODE_READ,  REG_CTRL,    8'h00,       1'b1, '{C_ENABLE | C_ERROR, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY2, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY1, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY2, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_CTRL,    C_START,     1'b1, '{8'h00, ST_NOT_ENABLED}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY1, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY2, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_CTRL,    C_START | C_ENABLE, 1'b1, '{8'h00, ST_RANGE}},
      '{MODE_WRITE, REG_ADDR_HI, 8'h00,       1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_DATA_HI, 8'hFF,       1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY1, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY2, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_CTRL,    C_START | C_ENABLE | C_LATCH, 1'b1, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY1, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY2, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_CTRL,    C_START | C_ENABLE, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_CTRL,    C_READ,      1'b0, '{8'h00, ST_OK}},
      '{MODE_READ,  REG_DATA_HI, 8'h00,       1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY1, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_UNLOCK,  UNLOCK_KEY2, 1'b0, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_CTRL,
        C_READ | C_START | C_ENABLE | C_ERASE | C_CONFIG, 1'b1, '{8'h00, ST_OK}},
      '{MODE_WRITE, REG_NONE_LO, 8'hFF,       1'b1, '{8'h00, ST_OK}}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = 1'b0;
   logic [IDX_W-1:0]  req_reg_index = '0;
   logic [BYTE_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_read_data;
   logic [STAT_W-1:0] rsp_status;

   logic [WORD_W-1:0] flash_mem [FW];
   logic [WORD_W-1:0] row_lat [RW];
   logic [ADDR_W-1:0] addr_q;
   logic [WORD_W-1:0] data_q;
   logic [BYTE_W-1:0] ctl_q;
   unlock_type        unlock_q;

   reply_type due_replies [$];
   reply_type want_reply;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit held = 1'b0;
   int items_sent = 0;
   int replies_seen = 0;
   int mismatches = 0;
   int programs = 0;
   int erases = 0;
   int latch_loads = 0;
   int refused_starts = 0;

   nvm_flash_row_controller dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap(inout bit calm);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic stat_type flash_start();
      int base;
      int slot;
      if (unlock_q != UL_OPEN) begin
         ctl_q[CTL_ERROR] = 1'b1;
         refused_starts++;
         return ST_LOCKED;
      end
      if (!ctl_q[CTL_ENABLE]) begin
         ctl_q[CTL_ERROR] = 1'b1;
         refused_starts++;
         return ST_NOT_ENABLED;
      end
      if (ctl_q[CTL_CONFIG]) return ST_OK;
      if (int'(addr_q) >= FW) return ST_RANGE;
      slot = int'(addr_q) % RW;
      base = int'(addr_q) - slot;
      if (ctl_q[CTL_ERASE]) begin
         for (int i = 0; i < RW; i++)
            if (base + i < FW) flash_mem[base + i] = WORD_ERASED;
         erases++;
         return ST_OK;
      end
      row_lat[slot] = data_q;
      if (ctl_q[CTL_LATCH]) begin
         latch_loads++;
         return ST_OK;
      end
      for (int i = 0; i < RW; i++)
         if (base + i < FW) flash_mem[base + i] &= row_lat[i];
      for (int i = 0; i < RW; i++) row_lat[i] = WORD_ERASED;
      programs++;
      return ST_OK;
   endfunction

   function automatic reply_type flash_access(input logic m, input logic [IDX_W-1:0] idx,
                                              input logic [BYTE_W-1:0] wd);
      reply_type r;
      stat_type  start_st;
      r.rd = '0;
      r.st = ST_OK;
      if (m != MODE_WRITE) begin
         unlock_q = UL_LOCKED;
         case (idx)
            REG_ADDR_LO: r.rd = addr_q[7:0];
            REG_ADDR_HI: r.rd = {1'b0, addr_q[14:8]};
            REG_DATA_LO: r.rd = data_q[7:0];
            REG_DATA_HI: r.rd = {2'b00, data_q[13:8]};
            REG_CTRL:    r.rd = ctl_q;
            default:     r.rd = '0;
         endcase
      end else if (idx == REG_UNLOCK) begin
         if (wd == UNLOCK_KEY1) unlock_q = UL_HALF;
         else if (wd == UNLOCK_KEY2 && unlock_q == UL_HALF) unlock_q = UL_OPEN;
         else unlock_q = UL_LOCKED;
      end else begin
         case (idx)
            REG_ADDR_LO: addr_q[7:0] = wd;
            REG_ADDR_HI: addr_q[14:8] = wd[6:0];
            REG_DATA_LO: data_q[7:0] = wd;
            REG_DATA_HI: data_q[13:8] = wd[5:0];
            REG_CTRL: begin
               ctl_q = wd & C_KEEP;
               if (wd[CTL_READ]) begin
                  if (ctl_q[CTL_CONFIG]) data_q = '0;
                  else if (int'(addr_q) < FW) data_q = flash_mem[addr_q];
                  else begin
                     data_q = '0;
                     r.st = ST_RANGE;
                  end
               end
               if (wd[CTL_START]) begin
                  start_st = flash_start();
                  if (start_st != ST_OK) r.st = start_st;
               end
            end
            default: ;
         endcase
         unlock_q = UL_LOCKED;
      end
      return r;
   endfunction

   task automatic send_item(input logic m, input logic [IDX_W-1:0] idx,
                            input logic [BYTE_W-1:0] wd, input logic typed,
                            input reply_type typed_reply);
      int gap;
      reply_type r;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_reg_index <= idx;
      req_write_data <= wd;
      do @(posedge clock); while (!(req_valid && req_ready));
      r = flash_access(m, idx, wd);
      due_replies.push_back(typed ? typed_reply : r);
      items_sent++;
   endtask

   task automatic put(input logic m, input logic [IDX_W-1:0] idx,
                      input logic [BYTE_W-1:0] wd);
      send_item(m, idx, wd, 1'b0, '0);
   endtask

   task automatic unlock_pair();
      case ($urandom_range(0, 19))
         0: put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY2);
         1: put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY1);
         2: begin
            put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY1);
            put(MODE_READ, REG_UNLOCK, BYTE_W'($urandom_range(0, 255)));
            put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY2);
         end
         3: begin
            put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY1);
            put(MODE_WRITE, REG_UNLOCK, BYTE_W'($urandom_range(0, 255)));
         end
         4: ;
         default: begin
            put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY1);
            put(MODE_WRITE, REG_UNLOCK, UNLOCK_KEY2);
         end
      endcase
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      case ($urandom_range(0, 9))
         0:       return ADDR_W'($urandom_range(0, 32767));
         1, 2, 3: return ADDR_W'($urandom_range(0, FW - 1));
         default: return ADDR_W'($urandom_range(0, 4 * RW - 1));
      endcase
   endfunction

   task automatic set_addr(input logic [ADDR_W-1:0] a);
      put(MODE_WRITE, REG_ADDR_LO, a[7:0]);
      put(MODE_WRITE, REG_ADDR_HI, {1'($urandom_range(0, 1)), a[14:8]});
   endtask

   task automatic set_data();
      put(MODE_WRITE, REG_DATA_LO, BYTE_W'($urandom_range(0, 255)));
      put(MODE_WRITE, REG_DATA_HI, BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic random_sequence();
      int kind;
      int n;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] row_base;
      logic [BYTE_W-1:0] c;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         // single command: erase, latch load, program or read
         if ($urandom_range(0, 3) != 0) set_addr(pick_addr());
         if ($urandom_range(0, 2) != 0) set_data();
         unlock_pair();
         c = BYTE_W'($urandom_range(0, 255));
         c[CTL_START]  = ($urandom_range(0, 9) != 0);
         c[CTL_ENABLE] = ($urandom_range(0, 9) != 0);
         c[CTL_CONFIG] = ($urandom_range(0, 9) == 0);
         c[CTL_ERASE]  = ($urandom_range(0, 5) == 0);
         c[CTL_LATCH]  = ($urandom_range(0, 1) == 0);
         c[CTL_READ]   = ($urandom_range(0, 3) == 0);
         put(MODE_WRITE, REG_CTRL, c);
      end else if (kind <= 7) begin
         // fill several latches of one row, program it, read a word back
         a = pick_addr();
         row_base = a - ADDR_W'(int'(a) % RW);
         n = $urandom_range(1, 6);
         set_addr(a);
         for (int k = 0; k < n; k++) begin
            put(MODE_WRITE, REG_ADDR_LO,
                8'(row_base + ADDR_W'((int'(a) % RW + k) % RW)));
            set_data();
            unlock_pair();
            put(MODE_WRITE, REG_CTRL, C_START | C_ENABLE | C_LATCH);
         end
         unlock_pair();
         put(MODE_WRITE, REG_CTRL, C_START | C_ENABLE);
         put(MODE_WRITE, REG_CTRL, C_READ);
         put(MODE_READ, REG_DATA_LO, 8'h00);
         put(MODE_READ, REG_DATA_HI, 8'h00);
      end else if (kind == 8) begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++)
            put(MODE_READ, IDX_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++)
            put(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 7)),
                BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int stall;
      forever begin
         stall = pick_gap(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (due_replies.size() == 0) begin
            $display("%0t: result with nothing expected: read_data %h status %0d",
                     $time, rsp_read_data, rsp_status);
            mismatches++;
         end else begin
            want_reply = due_replies.pop_front();
            if (rsp_read_data !== want_reply.rd) begin
               $display("%0t: read_data mismatch: expected %h, got %h",
                        $time, want_reply.rd, rsp_read_data);
               mismatches++;
            end
            if (rsp_status !== want_reply.st) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want_reply.st, rsp_status);
               mismatches++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < FW; i++) flash_mem[i] = WORD_ERASED;
      for (int i = 0; i < RW; i++) row_lat[i] = WORD_ERASED;
      addr_q = '0;
      data_q = '0;
      ctl_q = '0;
      unlock_q = UL_LOCKED;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_N; i++)
         send_item(DIRECTED[i].mode, DIRECTED[i].idx, DIRECTED[i].wd,
                   DIRECTED[i].typed, DIRECTED[i].want);
      while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
         if (!held && items_sent >= DIRECTED_N + RANDOM_ITEMS / 2) begin
            // drain the block completely before carrying on
            req_valid <= 1'b0;
            do @(posedge clock); while (due_replies.size() != 0);
            held = 1'b1;
         end
         random_sequence();
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (due_replies.size() != 0);
      repeat (END_WAIT) @(posedge clock);
      $display("Run covered %0d bus items (%0d directed) and %0d checked results.",
               items_sent, DIRECTED_N, replies_seen);
      $display("Flash work: %0d row programs, %0d row erases, %0d latch loads, %0d refused starts.",
               programs, erases, latch_loads, refused_starts);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("%0t: timeout, %0d results still outstanding", $time, due_replies.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/nvmfr_pkg.sv
hw/rtl/nvmfr_ctrl.sv
hw/rtl/nvmfr_datapath.sv
hw/rtl/nvm_flash_row_controller.sv
test/tb_top.sv
